// ===== sv/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store: op and status
// codes, widths, and the command broadcast to the row of storage cells.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int ST_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_ADD_FRONT = 3'd1,
    OP_ADD_BACK  = 3'd2,
    OP_INSERT    = 3'd3,
    OP_DELETE    = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   at;
    logic [DATA_W-1:0]  value;
  } cmd_t;

endpackage

// ===== sv/ils_if.sv =====
// ----------------------------------------------------------------------------
// ils_req_if / ils_rsp_if
// Valid/ready channels for requests into and results out of the list store.
// ----------------------------------------------------------------------------
interface ils_req_if;
  import ils_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] item_value;

  modport source (output valid, output op, output position, output item_value,
                  input ready);
  modport sink   (input valid, input op, input position, input item_value,
                  output ready);
endinterface

interface ils_rsp_if;
  import ils_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_value;
  logic [ST_W-1:0]   status;
  logic [LEN_W-1:0]  length_after;

  modport source (output valid, output read_value, output status,
                  output length_after, input ready);
  modport sink   (input valid, input read_value, input status,
                  input length_after, output ready);
endinterface

// ===== sv/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// One storage cell of the list: holds one value and, on an insert or a
// delete at or below its index, takes the new value or its neighbor's value.
// ----------------------------------------------------------------------------
module ils_cell (
  input  logic                        clk,
  input  ils_pkg::cmd_t               cmd,
  input  logic [ils_pkg::IDX_W-1:0]   cell_index,
  input  logic [ils_pkg::DATA_W-1:0]  prev_value,
  input  logic [ils_pkg::DATA_W-1:0]  next_value,
  output logic [ils_pkg::DATA_W-1:0]  value
);
  import ils_pkg::*;

  logic [DATA_W-1:0] value_next;

  always_comb begin
    value_next = value;
    case (cmd.kind)
      CMD_INSERT: begin
        if (cell_index == cmd.at) begin
          value_next = cmd.value;
        end else if (cell_index > cmd.at) begin
          value_next = prev_value;
        end
      end
      CMD_DELETE: begin
        if (cell_index >= cmd.at) begin
          value_next = next_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== sv/indexed_list_store_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Ordered list of signed values in a row of shifting cells, with read,
// add front, add back, insert and delete requests.
// ----------------------------------------------------------------------------
// result timing: registered on the edge that accepts its
//   request and is offered from the next cycle on
// throughput: one request per cycle while results are taken; a held result
//   stalls new requests; every cell shifts in parallel on the accepting edge
// reset: clears the length and the result valid flag; cell contents are
//   undefined until written and need no clearing
// ----------------------------------------------------------------------------
module indexed_list_store_top (
  input  logic       clk,
  input  logic       rst,
  ils_req_if.sink    req,
  ils_rsp_if.source  rsp
);
  import ils_pkg::*;

  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [LEN_W-1:0]  count;
  logic [LEN_W-1:0]  count_next;
  logic              accept;
  cmd_t              cmd;
  logic [DATA_W-1:0] rd;
  status_t           st;
  logic              full;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = count >= LEN_W'(CAPACITY);

  always_comb begin
    rd         = '1;
    st         = ST_DONE;
    cmd.kind   = CMD_HOLD;
    cmd.at     = '0;
    cmd.value  = req.item_value;
    count_next = count;
    case (req.op)
      OP_READ: begin
        if (req.position < count) begin
          rd = cell_val[req.position[IDX_W-1:0]];
        end else begin
          st = ST_RANGE;
        end
      end
      OP_ADD_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          cmd.kind = CMD_INSERT;
        end
      end
      OP_ADD_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          cmd.kind = CMD_INSERT;
          cmd.at   = count[IDX_W-1:0];
        end
      end
      OP_INSERT: begin
        if (req.position > count) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          cmd.kind = CMD_INSERT;
          cmd.at   = req.position[IDX_W-1:0];
        end
      end
      OP_DELETE: begin
        if (req.position >= count) begin
          st = ST_RANGE;
        end else begin
          cmd.kind = CMD_DELETE;
          cmd.at   = req.position[IDX_W-1:0];
        end
      end
      default: st = ST_DONE;
    endcase
    if (!accept) begin
      cmd.kind = CMD_HOLD;
    end
    if (cmd.kind == CMD_INSERT) begin
      count_next = count + LEN_W'(1);
    end else if (cmd.kind == CMD_DELETE) begin
      count_next = count - LEN_W'(1);
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_v;
    logic [DATA_W-1:0] next_v;
    if (i == 0) begin : g_first
      assign prev_v = req.item_value;
    end else begin : g_mid_prev
      assign prev_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_mid_next
      assign next_v = cell_val[i+1];
    end
    ils_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_index (IDX_W'(i)),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value   <= rd;
      rsp.status       <= st;
      rsp.length_after <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LEN_W'(CAPACITY))
    else $error("length above capacity");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_FULL |-> rsp.length_after == LEN_W'(CAPACITY))
    else $error("full status with room left");

  a_range_rd: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_RANGE |-> rsp.read_value == '1)
    else $error("range error with a read value");

  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid && rsp.length_after == count)
    else $error("result missing or length mismatch");

endmodule

// ===== tb/tb_indexed_list_store_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store_top
// Self-checking bench for the indexed list store. A shadow copy of the list
// predicts every result as requests are accepted. A short directed pass
// covers the empty-store edges, out-of-range positions, unused op codes and
// value extremes. Random phases then fill the store to capacity, drain it,
// and wander in between, with bursty stalls on both channels and a final
// stretch at full rate.
// ----------------------------------------------------------------------------
module tb_indexed_list_store_top;
  import ils_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    status_t           status;
    logic [LEN_W-1:0]  length_after;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rsp_ready_q = 1'b0;
  bit   idle_on = 1'b1;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   error_count = 0;
  int   request_count = 0;
  int   result_count = 0;
  int   full_rejects = 0;
  int   range_rejects = 0;
  int   peak_len = 0;

  logic [DATA_W-1:0] shadow_cells [0:CAPACITY-1];
  int                shadow_len = 0;
  list_result_t      pending_results [$];

  ils_req_if req ();
  ils_rsp_if rsp ();

  indexed_list_store_top uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #10 clk = ~clk;

  assign rsp.ready = rsp_ready_q;

  function automatic void open_cell(int at, logic [DATA_W-1:0] val);
    for (int i = shadow_len; i > at; i--) shadow_cells[i] = shadow_cells[i-1];
    shadow_cells[at] = val;
    shadow_len++;
  endfunction

  function automatic list_result_t apply_list_request(logic [OP_W-1:0] op,
                                                      logic [POS_W-1:0] pos,
                                                      logic [DATA_W-1:0] val);
    list_result_t r;
    int at;
    r.read_value = '1;
    r.status     = ST_DONE;
    at           = int'(pos);
    case (op)
      OP_READ: begin
        if (at < shadow_len) r.read_value = shadow_cells[at];
        else r.status = ST_RANGE;
      end
      OP_ADD_FRONT: begin
        if (shadow_len >= CAPACITY) r.status = ST_FULL;
        else open_cell(0, val);
      end
      OP_ADD_BACK: begin
        if (shadow_len >= CAPACITY) r.status = ST_FULL;
        else open_cell(shadow_len, val);
      end
      OP_INSERT: begin
        if (at > shadow_len) r.status = ST_RANGE;
        else if (shadow_len >= CAPACITY) r.status = ST_FULL;
        else open_cell(at, val);
      end
      OP_DELETE: begin
        if (at >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = at; i < shadow_len - 1; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len--;
        end
      end
      default: ;
    endcase
    r.length_after = shadow_len[LEN_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (error_count < 30)
      $display("[%0t] mismatch on result %0d, %s: got %0h, expected %0h",
               $time, result_count, what, got, want);
    error_count++;
  endtask

  // request tracking and result checking in one process so ordering is fixed
  always @(posedge clk) begin
    list_result_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        want = apply_list_request(req.op, req.position, req.item_value);
        pending_results.push_back(want);
        request_count++;
        if (want.status == ST_FULL) full_rejects++;
        if (want.status == ST_RANGE) range_rejects++;
        if (shadow_len > peak_len) peak_len = shadow_len;
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", rsp.read_value, '0);
        end else begin
          want = pending_results.pop_front();
          if (rsp.read_value !== want.read_value)
            report_mismatch("read_value", rsp.read_value, want.read_value);
          if (rsp.status !== want.status)
            report_mismatch("status", DATA_W'(rsp.status), DATA_W'(want.status));
          if (rsp.length_after !== want.length_after)
            report_mismatch("length_after", DATA_W'(rsp.length_after),
                            DATA_W'(want.length_after));
        end
        result_count++;
      end
    end
  end

  // result-side stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      rsp_ready_q <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(1, 8);
      rsp_ready_q <= 1'b0;
    end else begin
      rsp_ready_q <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("tb_indexed_list_store_top: done, errors");
      $finish;
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.op         <= op;
    req.position   <= pos;
    req.item_value <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    req.valid <= 1'b0;
    // let the checker record the request accepted on this edge
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_op(int w_read, int w_front, int w_back,
                                              int w_ins, int w_del, int w_bad);
    int r;
    r = $urandom_range(0, w_read + w_front + w_back + w_ins + w_del + w_bad - 1);
    if (r < w_read) return OP_READ;
    r -= w_read;
    if (r < w_front) return OP_ADD_FRONT;
    r -= w_front;
    if (r < w_back) return OP_ADD_BACK;
    r -= w_back;
    if (r < w_ins) return OP_INSERT;
    r -= w_ins;
    if (r < w_del) return OP_DELETE;
    return OP_W'($urandom_range(5, 7));
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int len;
    len = shadow_len;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return POS_W'($urandom_range(0, (len > 0) ? len - 1 : 0));
      6:                return POS_W'(len);
      7:                return POS_W'((len < 127) ? len + 1 : 127);
      8:                return POS_W'($urandom_range(0, 127));
      default: begin
        case ($urandom_range(0, 2))
          0:       return POS_W'(0);
          1:       return POS_W'(CAPACITY);
          default: return POS_W'(127);
        endcase
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic run_random_phase(int count, int w_read, int w_front, int w_back,
                                  int w_ins, int w_del, int w_bad);
    for (int n = 0; n < count; n++)
      send_request(pick_op(w_read, w_front, w_back, w_ins, w_del, w_bad),
                   pick_position(), pick_value());
  endtask

  task automatic test_directed_edges();
    send_request(OP_READ, 7'd0, 32'h0000_0000);
    send_request(OP_DELETE, 7'd0, 32'h0000_0000);
    send_request(OP_INSERT, 7'd1, 32'h5555_5555);
    send_request(3'd5, 7'd0, 32'hAAAA_AAAA);
    send_request(OP_INSERT, 7'd0, 32'h7FFF_FFFF);
    send_request(OP_ADD_FRONT, 7'd127, 32'h8000_0000);
    send_request(OP_ADD_BACK, 7'd64, 32'h0000_0000);
    send_request(OP_INSERT, 7'd3, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 7'd1, 32'h1234_5678);
    for (int p = 0; p <= 5; p++) send_request(OP_READ, POS_W'(p), 32'hFFFF_FFFF);
    send_request(OP_READ, 7'd127, 32'h0000_0000);
    send_request(3'd6, 7'd127, 32'hFFFF_FFFF);
    send_request(3'd7, 7'd64, 32'h0000_0000);
    send_request(OP_DELETE, 7'd5, 32'h0000_0000);
    send_request(OP_DELETE, 7'd4, 32'h0000_0000);
    send_request(OP_DELETE, 7'd0, 32'h0000_0000);
    send_request(OP_DELETE, 7'd1, 32'h0000_0000);
    send_request(OP_READ, 7'd0, 32'h0000_0000);
    send_request(OP_READ, 7'd1, 32'h0000_0000);
  endtask

  task automatic test_mixed_traffic(int count);
    run_random_phase(count, 30, 12, 12, 18, 22, 6);
  endtask

  task automatic test_fill_to_capacity(int count);
    run_random_phase(count, 20, 22, 22, 26, 6, 4);
  endtask

  task automatic test_drain_to_empty(int count);
    run_random_phase(count, 25, 5, 5, 5, 55, 5);
  endtask

  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    run_random_phase(count, 30, 14, 14, 18, 20, 4);
  endtask

  initial begin
    req.valid      = 1'b0;
    req.op         = '0;
    req.position   = '0;
    req.item_value = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    wait_for_results();
    test_mixed_traffic(400);
    test_fill_to_capacity(400);
    wait_for_results();
    test_drain_to_empty(300);
    test_mixed_traffic(250);
    test_back_to_back(200);

    wait_for_results();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never returned", '0, DATA_W'(pending_results.size()));

    $display("ran %0d requests, checked %0d results, peak length %0d of %0d",
             request_count, result_count, peak_len, CAPACITY);
    $display("store-full rejections %0d, out-of-range rejections %0d, mismatches %0d",
             full_rejects, range_rejects, error_count);
    if (error_count == 0) begin
      $display("tb_indexed_list_store_top: done, clean");
    end else begin
      $display("tb_indexed_list_store_top: done, errors");
    end
    $finish;
  end

endmodule
